>>> design/msbbr_pkg.sv
package msbbr_pkg;

	localparam int DEFAULT_BUFFER_BYTES = 4096;
	localparam int LEN_W = 13;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// register index, taken from paddr[2]
	localparam logic REG_STREAM_LENGTH = 1'b0;

	typedef enum logic [2:0] {
		FUNC_LOAD       = 3'd0,
		FUNC_READ_BITS  = 3'd1,
		FUNC_READ_SAMPLE = 3'd2,
		FUNC_SKIP_BITS  = 3'd3,
		FUNC_SKIP_BYTES = 3'd4,
		FUNC_ALIGN      = 3'd5,
		FUNC_READ_LE    = 3'd6,
		FUNC_READ_BE    = 3'd7
	} func_t;

	typedef struct packed {
		func_t       func;
		logic [6:0]  bit_count;
		logic [4:0]  shift_amount;
		logic [15:0] skip_amount;
		logic [11:0] load_address;
		logic [7:0]  load_byte;
	} in_item_t;

	typedef struct packed {
		logic [63:0]      value;
		logic             is_empty;
		logic             overrun;
		logic             misaligned;
		logic [LEN_W-1:0] byte_position;
	} out_item_t;

endpackage

>>> design/msb_first_bit_reader.sv
// msb-first bitstream reader
// items enter on in_valid/in_ready as msbbr_pkg::in_item_t; every item gives exactly
// one result on out_valid/out_ready as msbbr_pkg::out_item_t.
// load items write one byte of the buffer; all other items read, skip or align
// from the current position, most significant bit first.
// stream_length sits at byte address 0 of the apb port; write it only while idle.
// an item passes through fetch, extract and finish; items that fetch no bytes
// (load, skips, align, misaligned byte read, zero count) go straight through
// fetch, and a 64-bit read that spans nine buffer bytes fetches the most.
// the single read port of the byte memory gives one byte per cycle with a
// registered read, ahead of the extract and finish states.
// the result appears in the output register at the end of the item; a new item
// is accepted while that result still waits for out_ready, and an item that
// finishes while the output is held waits in its finish state.
// reset clears the position, stream_length and the output valid; the buffer
// contents are not cleared and must be loaded before they are read.
module msb_first_bit_reader #(
	parameter int BUFFER_BYTES = msbbr_pkg::DEFAULT_BUFFER_BYTES
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  msbbr_pkg::in_item_t               in_item,
	output logic                              out_valid,
	input  logic                              out_ready,
	output msbbr_pkg::out_item_t              out_item,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [msbbr_pkg::PADDR_W-1:0]     paddr,
	input  logic [msbbr_pkg::PDATA_W-1:0]     pwdata,
	output logic [msbbr_pkg::PDATA_W-1:0]     prdata,
	output logic                              pready
);

	localparam int LEN_W = msbbr_pkg::LEN_W;
	localparam int AW    = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
	localparam int POS_W = LEN_W + 3;   // bit position
	localparam int END_W = POS_W + 5;   // position plus a full byte skip
	localparam int FA_W  = LEN_W + 1;   // fetch byte address, position plus eight

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_EXTRACT,
		ST_FINISH
	} state_t;

	// buffer address wrap for loads; quotient is below 256 since BUFFER_BYTES >= 16
	function automatic logic [11:0] wrap_addr(input logic [11:0] a);
		logic [12:0] r;
		r = {1'b0, a};
		if (BUFFER_BYTES < 4096) begin
			for (int k = 7; k >= 0; k--) begin
				if (int'(r) >= (BUFFER_BYTES << k)) begin
					r = r - 13'(BUFFER_BYTES << k);
				end
			end
		end
		return r[11:0];
	endfunction

	// control state
	state_t                 state_q;
	logic [LEN_W-1:0]       stream_length_q;
	logic [LEN_W-1:0]       byte_index_q;
	logic [2:0]             bit_off_q;      // 8 - bits remaining
	logic                   out_valid_q;
	msbbr_pkg::out_item_t   out_item_q;
	logic                   rd_s1;          // read data lands this cycle
	logic                   zero_s1;        // landing byte lies past the stream end

	// datapath registers
	msbbr_pkg::func_t       func_q;
	logic [6:0]             len_q;          // field width in bits
	logic [4:0]             sh_q;
	logic [END_W-1:0]       end_q;
	logic                   hold_q;         // position does not move
	logic                   mis_q;
	logic [3:0]             nb_q;
	logic [3:0]             issued_q;
	logic [3:0]             recv_q;
	logic [FA_W-1:0]        fetch_addr_q;
	logic [2:0]             sa_q;
	logic [71:0]            acc_q;
	logic [63:0]            le_q;
	logic [63:0]            field_q;
	logic [7:0]             rdata_s1;

	logic [7:0]             mem [BUFFER_BYTES];

	// effective length and handshakes
	logic [LEN_W-1:0]       eff_len;
	logic                   in_fire;
	logic                   cfg_write;
	logic                   out_free;

	assign eff_len = (int'(stream_length_q) > BUFFER_BYTES) ? LEN_W'(BUFFER_BYTES)
		: stream_length_q;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign cfg_write = psel && penable && pwrite && (paddr[2] == msbbr_pkg::REG_STREAM_LENGTH);
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;
	assign pready    = 1'b1;
	assign prdata    = (paddr[2] == msbbr_pkg::REG_STREAM_LENGTH)
		? msbbr_pkg::PDATA_W'(stream_length_q) : '0;

	// decode of an arriving item
	logic [POS_W-1:0]       cur_pos;
	logic [6:0]             n_bits;
	logic [6:0]             n_depth;
	logic [3:0]             n_bytes;
	logic [6:0]             dec_len;
	logic [END_W-1:0]       dec_end;
	logic [END_W-1:0]       align_sum;
	logic [3:0]             dec_nb;
	logic [6:0]             nb_span;
	logic                   dec_hold;
	logic                   dec_mis;
	logic [6:0]             dec_sa;

	always_comb begin
		cur_pos   = {byte_index_q, bit_off_q};
		n_bits    = (in_item.bit_count > 7'd64) ? 7'd64 : in_item.bit_count;
		n_depth   = (in_item.bit_count > 7'd32) ? 7'd32 : in_item.bit_count;
		n_bytes   = (in_item.bit_count > 7'd8) ? 4'd8 : in_item.bit_count[3:0];
		align_sum = END_W'(cur_pos) + END_W'(7);
		dec_len   = '0;
		dec_end   = END_W'(cur_pos);
		dec_nb    = '0;
		dec_hold  = 1'b0;
		dec_mis   = 1'b0;
		case (in_item.func)
			msbbr_pkg::FUNC_LOAD: begin
				dec_hold = 1'b1;
			end
			msbbr_pkg::FUNC_READ_BITS: begin
				dec_len = n_bits;
			end
			msbbr_pkg::FUNC_READ_SAMPLE: begin
				dec_len = n_depth;
			end
			msbbr_pkg::FUNC_SKIP_BITS: begin
				dec_end = END_W'(cur_pos) + END_W'(in_item.skip_amount);
			end
			msbbr_pkg::FUNC_SKIP_BYTES: begin
				dec_end = END_W'(cur_pos) + END_W'({in_item.skip_amount, 3'b000});
			end
			msbbr_pkg::FUNC_ALIGN: begin
				dec_end = {align_sum[END_W-1:3], 3'b000};
			end
			default: begin
				// byte reads only from a byte boundary
				if (bit_off_q != 3'd0) begin
					dec_hold = 1'b1;
					dec_mis  = 1'b1;
				end else begin
					dec_len = {n_bytes, 3'b000};
				end
			end
		endcase
		// bit-field reads and byte reads share one fetch of whole bytes
		nb_span = 7'(bit_off_q) + dec_len + 7'd7;
		if (dec_len != 7'd0) begin
			dec_nb  = nb_span[6:3];
			dec_end = END_W'(cur_pos) + END_W'(dec_len);
		end
		dec_sa = {dec_nb, 3'b000} - 7'(bit_off_q) - dec_len;
	end

	// field extraction from the fetched bytes
	logic [71:0]            acc_shift;
	logic [63:0]            field_mask;
	logic [7:0]             fetched_byte;

	assign fetched_byte = zero_s1 ? 8'd0 : rdata_s1;
	assign acc_shift    = acc_q >> sa_q;
	assign field_mask   = (len_q >= 7'd64) ? '1 : ((64'd1 << len_q) - 64'd1);

	// finish: value, clamp and flags
	logic [63:0]            sample_shift;
	logic [6:0]             sample_width;
	logic [5:0]             sign_pos;
	logic [63:0]            result_value;
	logic [POS_W-1:0]       limit_pos;
	logic                   result_ovr;
	logic [END_W-1:0]       clamped_end;
	logic [LEN_W-1:0]       next_index;
	logic [2:0]             next_off;

	always_comb begin
		sample_shift = field_q << sh_q;
		sample_width = len_q + 7'(sh_q);
		sign_pos     = 6'(sample_width - 7'd1);
		case (func_q)
			msbbr_pkg::FUNC_READ_BITS: result_value = field_q;
			msbbr_pkg::FUNC_READ_SAMPLE: begin
				result_value = sample_shift;
				if (sample_width != 7'd0 && sample_shift[sign_pos]) begin
					result_value = sample_shift | ({64{1'b1}} << sign_pos);
				end
			end
			msbbr_pkg::FUNC_READ_LE: result_value = mis_q ? 64'd0 : le_q;
			msbbr_pkg::FUNC_READ_BE: result_value = mis_q ? 64'd0 : field_q;
			default: result_value = 64'd0;
		endcase
		limit_pos   = {eff_len, 3'b000};
		result_ovr  = !hold_q && (end_q > END_W'(limit_pos));
		clamped_end = result_ovr ? END_W'(limit_pos) : end_q;
		next_index  = hold_q ? byte_index_q : clamped_end[POS_W-1:3];
		next_off    = hold_q ? bit_off_q : clamped_end[2:0];
	end

	// state machine, position and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			stream_length_q <= '0;
			byte_index_q    <= '0;
			bit_off_q       <= '0;
			out_valid_q     <= 1'b0;
			out_item_q      <= '0;
			rd_s1           <= 1'b0;
			zero_s1         <= 1'b0;
		end else begin
			if (cfg_write) begin
				stream_length_q <= pwdata[LEN_W-1:0];
			end
			if (state_q == ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			rd_s1 <= (state_q == ST_FETCH) && (issued_q != nb_q);
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					if (issued_q != nb_q) begin
						zero_s1 <= fetch_addr_q >= FA_W'(eff_len);
					end else if (!rd_s1) begin
						state_q <= ST_EXTRACT;
					end
				end
				ST_EXTRACT: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_free) begin
						out_item_q.value           <= result_value;
						out_item_q.is_empty        <= next_index >= eff_len;
						out_item_q.overrun         <= result_ovr;
						out_item_q.misaligned      <= mis_q;
						out_item_q.byte_position   <= next_index;
						byte_index_q               <= next_index;
						bit_off_q                  <= next_off;
						state_q                    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			func_q       <= in_item.func;
			len_q        <= dec_len;
			sh_q         <= in_item.shift_amount;
			end_q        <= dec_end;
			hold_q       <= dec_hold;
			mis_q        <= dec_mis;
			nb_q         <= dec_nb;
			sa_q         <= dec_sa[2:0];
			issued_q     <= '0;
			recv_q       <= '0;
			fetch_addr_q <= FA_W'(byte_index_q);
			acc_q        <= '0;
			le_q         <= '0;
		end
		if (state_q == ST_FETCH && issued_q != nb_q) begin
			issued_q     <= issued_q + 4'd1;
			fetch_addr_q <= fetch_addr_q + FA_W'(1);
		end
		if (rd_s1) begin
			acc_q                  <= {acc_q[63:0], fetched_byte};
			le_q[recv_q[2:0]*8 +: 8] <= fetched_byte;
			recv_q                 <= recv_q + 4'd1;
		end
		if (state_q == ST_EXTRACT) begin
			field_q <= acc_shift[63:0] & field_mask;
		end
	end

	// byte buffer: one write port for loads, one read port for fetches; loads and
	// fetches never overlap since one item is in flight at a time
	always_ff @(posedge clk) begin
		if (in_fire && in_item.func == msbbr_pkg::FUNC_LOAD) begin
			mem[AW'(wrap_addr(in_item.load_address))] <= in_item.load_byte;
		end
		if (state_q == ST_FETCH && issued_q != nb_q) begin
			rdata_s1 <= mem[AW'(fetch_addr_q)];
		end
	end

endmodule

>>> test/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STORE_BYTES = msbbr_pkg::DEFAULT_BUFFER_BYTES;
	localparam int LOADED_BYTES = 128;  // reads of stream data never reach past this window
	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 20;
	localparam int PHASE_ITEMS = 52;
	localparam int IN_BITS = $bits(msbbr_pkg::in_item_t);
	localparam int LEN_W = msbbr_pkg::LEN_W;

	// clock, reset and the two handshake channels
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	msbbr_pkg::in_item_t in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	msbbr_pkg::out_item_t out_item;

	// configuration port, idle until a register write
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [msbbr_pkg::PADDR_W-1:0] paddr = '0;
	logic [msbbr_pkg::PDATA_W-1:0] pwdata = '0;
	logic [msbbr_pkg::PDATA_W-1:0] prdata;
	logic pready;

	// items waiting to be sent, and results the block still owes us
	msbbr_pkg::in_item_t pending_cmds[$];
	msbbr_pkg::out_item_t due_results[$];

	int stall_pct = 14;
	int err_cnt = 0;
	int cyc_cnt = 0;

	// shadow copy of the reader: byte store, read position and stream length
	logic [7:0] shadow_mem [0:STORE_BYTES-1];
	logic [LEN_W-1:0] cur_byte = '0;
	logic [3:0] unread_bits = 4'd8;
	logic [LEN_W-1:0] len_cfg = '0;

	msb_first_bit_reader i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// shadow reader
	// ---------------------------------------------------------------

	// stream length as the block sees it, never beyond the store
	function automatic longint usable_len();
		return (len_cfg > LEN_W'(STORE_BYTES)) ? longint'(STORE_BYTES) : longint'(len_cfg);
	endfunction

	function automatic longint cur_bit();
		return longint'(cur_byte) * 8 + (8 - longint'(unread_bits));
	endfunction

	// bytes at or past the stream end read as zero
	function automatic logic [7:0] peek_byte(longint addr);
		if (addr >= usable_len()) begin
			return 8'h00;
		end
		return shadow_mem[addr[11:0]];
	endfunction

	function automatic logic peek_bit(longint pos);
		logic [7:0] b;
		b = peek_byte(pos >> 3);
		return b[3'd7 - pos[2:0]];
	endfunction

	// jump to a bit position, clamped at the stream end; returns overrun
	function automatic logic move_pos(longint stop);
		longint lim;
		logic ovr;
		lim = usable_len() * 8;
		ovr = 1'b0;
		if (stop > lim) begin
			ovr = 1'b1;
			stop = lim;
		end
		cur_byte = LEN_W'(stop >> 3);
		unread_bits = 4'(8 - (stop & 7));
		return ovr;
	endfunction

	// msb-first field of n bits from the current position
	function automatic logic [63:0] pull_bits(int n, output logic ovr);
		longint start;
		logic [63:0] v;
		start = cur_bit();
		v = '0;
		for (int i = 0; i < n; i++) begin
			v = {v[62:0], peek_bit(start + i)};
		end
		ovr = move_pos(start + n);
		return v;
	endfunction

	// one item in, the result it must produce out
	function automatic msbbr_pkg::out_item_t bitstream_step(msbbr_pkg::in_item_t it);
		msbbr_pkg::out_item_t r;
		logic [63:0] v;
		logic ovr;
		logic mis;
		logic [7:0] b;
		int n;
		int w;
		longint base;
		v = '0;
		ovr = 1'b0;
		mis = 1'b0;
		case (it.func)
			msbbr_pkg::FUNC_LOAD: begin
				shadow_mem[it.load_address] = it.load_byte;
			end
			msbbr_pkg::FUNC_READ_BITS: begin
				n = (it.bit_count > 7'd64) ? 64 : int'(it.bit_count);
				v = pull_bits(n, ovr);
			end
			msbbr_pkg::FUNC_READ_SAMPLE: begin
				// depth capped at 32, sign taken from the top of the shifted field
				n = (it.bit_count > 7'd32) ? 32 : int'(it.bit_count);
				w = n + int'(it.shift_amount);
				v = pull_bits(n, ovr) << it.shift_amount;
				if (w > 0 && v[w-1]) begin
					v = v | ({64{1'b1}} << (w - 1));
				end
			end
			msbbr_pkg::FUNC_SKIP_BITS: begin
				ovr = move_pos(cur_bit() + longint'(it.skip_amount));
			end
			msbbr_pkg::FUNC_SKIP_BYTES: begin
				ovr = move_pos(cur_bit() + longint'(it.skip_amount) * 8);
			end
			msbbr_pkg::FUNC_ALIGN: begin
				ovr = move_pos((cur_bit() + 7) & ~longint'(7));
			end
			default: begin
				// byte reads, only on a byte boundary
				n = (it.bit_count > 7'd8) ? 8 : int'(it.bit_count);
				if (unread_bits != 4'd8) begin
					mis = 1'b1;
				end else begin
					base = longint'(cur_byte);
					for (int k = 0; k < n; k++) begin
						b = peek_byte(base + k);
						if (it.func == msbbr_pkg::FUNC_READ_LE) begin
							v = v | (64'(b) << (8 * k));
						end else begin
							v = (v << 8) | 64'(b);
						end
					end
					ovr = move_pos((base + n) * 8);
				end
			end
		endcase
		r.value = v;
		r.is_empty = (longint'(cur_byte) >= usable_len());
		r.overrun = ovr;
		r.misaligned = mis;
		r.byte_position = cur_byte;
		return r;
	endfunction

	// ---------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------

	// command with chosen fields; the fields it ignores get random values
	function automatic msbbr_pkg::in_item_t cmd(msbbr_pkg::func_t f, int cnt = 0, int sh = 0,
			int skip = 0);
		msbbr_pkg::in_item_t it;
		it = msbbr_pkg::in_item_t'(IN_BITS'({$urandom, $urandom}));
		it.func = f;
		it.bit_count = 7'(cnt);
		it.shift_amount = 5'(sh);
		it.skip_amount = 16'(skip);
		return it;
	endfunction

	// random command, counts and skips mostly in the useful range
	function automatic msbbr_pkg::in_item_t rand_cmd();
		msbbr_pkg::in_item_t it;
		int pick;
		logic wide;
		it = msbbr_pkg::in_item_t'(IN_BITS'({$urandom, $urandom}));
		pick = $urandom_range(99);
		wide = ($urandom_range(9) == 0);
		if (pick < 10) begin
			it.func = msbbr_pkg::FUNC_LOAD;
		end else if (pick < 32) begin
			it.func = msbbr_pkg::FUNC_READ_BITS;
		end else if (pick < 47) begin
			it.func = msbbr_pkg::FUNC_READ_SAMPLE;
		end else if (pick < 57) begin
			it.func = msbbr_pkg::FUNC_SKIP_BITS;
		end else if (pick < 65) begin
			it.func = msbbr_pkg::FUNC_SKIP_BYTES;
		end else if (pick < 75) begin
			it.func = msbbr_pkg::FUNC_ALIGN;
		end else if (pick < 87) begin
			it.func = msbbr_pkg::FUNC_READ_LE;
		end else begin
			it.func = msbbr_pkg::FUNC_READ_BE;
		end
		// wide picks keep the full random field, counts past the caps included
		if (!wide) begin
			case (it.func)
				msbbr_pkg::FUNC_READ_BITS: it.bit_count = 7'($urandom_range(64));
				msbbr_pkg::FUNC_READ_SAMPLE: it.bit_count = 7'($urandom_range(32));
				msbbr_pkg::FUNC_SKIP_BITS: it.skip_amount = 16'($urandom_range(40));
				msbbr_pkg::FUNC_SKIP_BYTES: it.skip_amount = 16'($urandom_range(12));
				msbbr_pkg::FUNC_READ_LE, msbbr_pkg::FUNC_READ_BE:
					it.bit_count = 7'($urandom_range(8));
				default: ;
			endcase
		end
		return it;
	endfunction

	// wait until every sent item has its result back, then let the block go quiet
	task automatic settle();
		do begin
			@(negedge clk);
		end while (pending_cmds.size() != 0 || in_valid || due_results.size() != 0);
		repeat (TAIL_CYCLES) @(negedge clk);
	endtask

	// setup then access; the register takes the value when pready is seen
	task automatic write_len(int len);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {msbbr_pkg::REG_STREAM_LENGTH, 2'b00};
		pwdata <= msbbr_pkg::PDATA_W'(len);
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(posedge clk);
		end while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		len_cfg = LEN_W'(len);
	endtask

	// ---------------------------------------------------------------
	// driver: feeds pending items, holds valid and payload until taken
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			due_results.push_back(bitstream_step(in_item));
		end
		if (!in_valid || in_ready) begin
			if (pending_cmds.size() != 0 && $urandom_range(99) >= stall_pct) begin
				in_item <= pending_cmds.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// monitor: random back-pressure, every result checked against the oldest due
	// ---------------------------------------------------------------
	task automatic cmp_field(string tag, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			err_cnt++;
			$display("%0t: %s mismatch, expected %h, got %h", $time, tag, want, got);
		end
	endtask

	always @(posedge clk) begin : mon
		msbbr_pkg::out_item_t want;
		out_ready <= ($urandom_range(99) >= stall_pct);
		if (out_valid && out_ready) begin
			if (due_results.size() == 0) begin
				err_cnt++;
				$display("%0t: result with nothing expected, got %h", $time, out_item);
			end else begin
				want = due_results.pop_front();
				cmp_field("value", want.value, out_item.value);
				cmp_field("is_empty", 64'(want.is_empty), 64'(out_item.is_empty));
				cmp_field("overrun", 64'(want.overrun), 64'(out_item.overrun));
				cmp_field("misaligned", 64'(want.misaligned), 64'(out_item.misaligned));
				cmp_field("byte_position", 64'(want.byte_position),
					64'(out_item.byte_position));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cyc_cnt <= cyc_cnt + 1;
		if (cyc_cnt == CYCLE_LIMIT) begin
			$display("%0t: timeout", $time);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// test sequence
	// ---------------------------------------------------------------
	initial begin
		msbbr_pkg::in_item_t it;
		int new_len;
		int pos;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// empty stream straight out of reset: everything past the end
		pending_cmds.push_back(cmd(msbbr_pkg::FUNC_READ_BITS, 64));
		pending_cmds.push_back(cmd(msbbr_pkg::FUNC_READ_LE, 8));
		pending_cmds.push_back(cmd(msbbr_pkg::FUNC_ALIGN));
		pending_cmds.push_back(cmd(msbbr_pkg::FUNC_SKIP_BYTES, 0, 0, 1));

		// fill the window that every read of stream data stays inside
		for (int a = 0; a < LOADED_BYTES; a++) begin
			it = cmd(msbbr_pkg::FUNC_LOAD);
			it.load_address = 12'(a);
			pending_cmds.push_back(it);
		end
		settle();
		write_len(64);

		// directed walk through a 64-byte stream
		pending_cmds.push_back(cmd(msbbr_pkg::FUNC_READ_BITS, 0));          // zero count
		pending_cmds.push_back(cmd(msbbr_pkg::FUNC_READ_BITS, 1));
		pending_cmds.push_back(cmd(msbbr_pkg::FUNC_READ_BITS, 127));        // capped at 64
		pending_cmds.push_back(cmd(msbbr_pkg::FUNC_READ_SAMPLE, 32, 0));
		// depth capped, widest shift
		pending_cmds.push_back(cmd(msbbr_pkg::FUNC_READ_SAMPLE, 127, 31));
		pending_cmds.push_back(cmd(msbbr_pkg::FUNC_READ_SAMPLE, 0, 5));     // zero depth
		pending_cmds.push_back(cmd(msbbr_pkg::FUNC_READ_SAMPLE, 5, 31));
		// now off a byte boundary
		pending_cmds.push_back(cmd(msbbr_pkg::FUNC_SKIP_BITS, 0, 0, 3));
		pending_cmds.push_back(cmd(msbbr_pkg::FUNC_READ_LE, 4));            // misaligned
		pending_cmds.push_back(cmd(msbbr_pkg::FUNC_READ_BE, 8));            // misaligned
		pending_cmds.push_back(cmd(msbbr_pkg::FUNC_ALIGN));
		pending_cmds.push_back(cmd(msbbr_pkg::FUNC_READ_LE, 8));
		pending_cmds.push_back(cmd(msbbr_pkg::FUNC_READ_BE, 127));          // capped at 8 bytes
		pending_cmds.push_back(cmd(msbbr_pkg::FUNC_READ_LE, 0));
		pending_cmds.push_back(cmd(msbbr_pkg::FUNC_SKIP_BYTES, 0, 0, 20));
		pending_cmds.push_back(cmd(msbbr_pkg::FUNC_SKIP_BITS, 0, 0, 0));
		pending_cmds.push_back(cmd(msbbr_pkg::FUNC_READ_BITS, 64));
		pending_cmds.push_back(cmd(msbbr_pkg::FUNC_READ_BE, 8));            // runs off the end
		pending_cmds.push_back(cmd(msbbr_pkg::FUNC_SKIP_BITS, 0, 0, 65535));
		settle();

		// shorter stream than the current position: next item pulls it back
		write_len(8);
		pending_cmds.push_back(cmd(msbbr_pkg::FUNC_READ_BITS, 1));
		settle();

		// length beyond the store: the position stops at the store end
		write_len(8191);
		pending_cmds.push_back(cmd(msbbr_pkg::FUNC_SKIP_BYTES, 0, 0, 65535));
		pending_cmds.push_back(cmd(msbbr_pkg::FUNC_READ_BITS, 64));
		pending_cmds.push_back(cmd(msbbr_pkg::FUNC_READ_BE, 8));
		settle();

		// random phases, each with a fresh window inside the loaded bytes
		for (int ph = 0; ph < 8; ph++) begin
			pos = int'(cur_byte);
			if (ph != 3) begin
				// an empty stream pulls the position back to the start
				write_len(0);
				pending_cmds.push_back(cmd(msbbr_pkg::FUNC_ALIGN));
				settle();
			end
			case (ph)
				1: new_len = 0;                                // empty from the start
				3: new_len = (pos > 3) ? pos - $urandom_range(1, 3) : 0;
				7: new_len = LOADED_BYTES;                     // whole loaded window
				default: new_len = $urandom_range(16, LOADED_BYTES);
			endcase
			write_len(new_len);
			// one stretch with no idling on either side
			stall_pct = (ph == 5) ? 0 : 14;
			for (int i = 0; i < ((ph == 1) ? 30 : PHASE_ITEMS); i++) begin
				it = rand_cmd();
				// about half the byte reads are set up by an align first
				if ((it.func == msbbr_pkg::FUNC_READ_LE || it.func == msbbr_pkg::FUNC_READ_BE) &&
						$urandom_range(1) == 1) begin
					pending_cmds.push_back(cmd(msbbr_pkg::FUNC_ALIGN));
				end
				pending_cmds.push_back(it);
				// sender holds off once until the block has drained
				if (ph == 2 && i == PHASE_ITEMS / 2) begin
					settle();
				end
			end
			settle();
		end

		if (err_cnt == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

>>> sim.f
design/msbbr_pkg.sv
design/msb_first_bit_reader.sv
test/tb_top.sv
